// ----- rtl/csa_pkg.sv -----
// Shared types and constants for the chi-square pair accumulator.
`default_nettype none

package csa_pkg;

    // Field widths of the data path.
    localparam int VAL_W     = 24;
    localparam int FR_W      = 16;
    localparam int IDX_W     = 16;
    localparam int SUM_W     = 48;
    localparam int FRAC_BITS = 16;

    // Width of the shifted numerator inside the divider.
    localparam int N_W   = VAL_W + FRAC_BITS;
    // Step counters count down from the longest serial loop.
    localparam int CNT_W = $clog2(VAL_W + 1);

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Magnification used outside the profile range: 1.0, clamped to the value range.
    localparam logic [VAL_W-1:0] ONE_VAL =
        (FRAC_BITS >= VAL_W) ? VAL_MAX : VAL_W'(1 << FRAC_BITS);

    // Handshake status reported by each serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } csa_stat_t;

endpackage

`default_nettype wire

// ----- rtl/chi_square_pair_accumulator.sv -----
// Top level of the chi-square pair accumulator: sequencer, running sum and result register.
//
// Usage: each item on the s_ channel is one data point of a light-curve pair.
// Both magnifications are interpolated, their ratio is compared with the
// observed value, the residual is scaled by sigma, squared and added to a
// running sum. An item with s_last_point set produces one item on the m_
// channel carrying the pair's sum, its destination index and a flag that
// reports any clamp during the pair; the sum and flag then clear.
// One item is processed at a time. After acceptance, s_ready returns only
// once the item has passed the interpolation (16 multiply steps and a
// final add), three 24-step bit-serial loops (ratio divide, residual
// divide, square), a handoff after each unit and the accumulate step; a
// saturating divide skips its loop. For a last point, m_valid rises
// together with s_ready.
// Reset (aresetn low, synchronous) clears the sum, the flag, the sequencer
// and m_valid. A result waits in the output register while the next item
// is accepted and processed; only when another result is due and the
// previous one has not been taken does the block wait for m_ready.
`default_nettype none

module chi_square_pair_accumulator (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [csa_pkg::VAL_W-1:0]  s_sample_a,
    input  wire logic [csa_pkg::VAL_W-1:0]  s_slope_a,
    input  wire logic [csa_pkg::FR_W-1:0]   s_frac_a,
    input  wire logic                       s_outside_a,
    input  wire logic [csa_pkg::VAL_W-1:0]  s_sample_b,
    input  wire logic [csa_pkg::VAL_W-1:0]  s_slope_b,
    input  wire logic [csa_pkg::FR_W-1:0]   s_frac_b,
    input  wire logic                       s_outside_b,
    input  wire logic [csa_pkg::VAL_W-1:0]  s_observed,
    input  wire logic [csa_pkg::VAL_W-1:0]  s_sigma,
    input  wire logic [csa_pkg::IDX_W-1:0]  s_dest_index,
    input  wire logic                       s_last_point,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [csa_pkg::SUM_W-1:0]       m_chi2_sum,
    output logic [csa_pkg::IDX_W-1:0]       m_result_index,
    output logic                            m_saturated
);
    import csa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTERP,
        ST_RATIO,
        ST_QUOT,
        ST_SQUARE,
        ST_ACC
    } state_t;

    state_t            state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              seen_reg, seen_next;
    logic              ptclamp_reg, ptclamp_next;
    logic              m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]  m_sum_reg, m_sum_next;
    logic [IDX_W-1:0]  m_idx_reg, m_idx_next;
    logic              m_sat_reg, m_sat_next;
    logic [VAL_W-1:0]  obs_reg;
    logic [VAL_W-1:0]  sigma_reg;
    logic [IDX_W-1:0]  dest_reg;
    logic              last_reg;

    logic              accept;
    logic              interp_start;
    logic              div_start;
    logic [VAL_W-1:0]  div_num;
    logic [VAL_W-1:0]  div_den;
    logic              sq_start;

    logic [VAL_W-1:0]  mag_a, mag_b;
    logic              clamp_a, clamp_b;
    csa_stat_t         ia_stat, ib_stat;
    logic [VAL_W-1:0]  div_quo;
    logic              div_clamp;
    csa_stat_t         div_stat;
    logic [SUM_W-1:0]  sq_val;
    csa_stat_t         sq_stat;

    logic [VAL_W-1:0]  residual;
    logic [SUM_W:0]    acc_full;
    logic [SUM_W-1:0]  acc_sum;
    logic              acc_flag;

    // Serial units.
    csa_interp u_interp_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (interp_start),
        .sample  (s_sample_a),
        .slope   (s_slope_a),
        .frac    (s_frac_a),
        .outside (s_outside_a),
        .mag     (mag_a),
        .clamp   (clamp_a),
        .stat    (ia_stat)
    );

    csa_interp u_interp_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (interp_start),
        .sample  (s_sample_b),
        .slope   (s_slope_b),
        .frac    (s_frac_b),
        .outside (s_outside_b),
        .mag     (mag_b),
        .clamp   (clamp_b),
        .stat    (ib_stat)
    );

    // One divider serves both the ratio and the residual quotient.
    csa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .clamp   (div_clamp),
        .stat    (div_stat)
    );

    csa_square u_square (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .q       (div_quo),
        .sq      (sq_val),
        .stat    (sq_stat)
    );

    assign accept = s_valid && s_ready;

    // Residual magnitude and saturating accumulation.
    always_comb begin
        residual = (obs_reg >= div_quo) ? obs_reg - div_quo : div_quo - obs_reg;
        acc_full = {1'b0, sum_reg} + {1'b0, sq_val};
        acc_sum  = acc_full[SUM_W] ? SUM_MAX : acc_full[SUM_W-1:0];
        acc_flag = seen_reg || ptclamp_reg || acc_full[SUM_W];
    end

    // Sequencer: hands each item from unit to unit and retires it.
    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        seen_next    = seen_reg;
        ptclamp_next = ptclamp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_sum_next   = m_sum_reg;
        m_idx_next   = m_idx_reg;
        m_sat_next   = m_sat_reg;
        interp_start = 1'b0;
        div_start    = 1'b0;
        div_num      = mag_a;
        div_den      = mag_b;
        sq_start     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    interp_start = 1'b1;
                    ptclamp_next = 1'b0;
                    state_next   = ST_INTERP;
                end
            end
            ST_INTERP: begin
                if (ia_stat.done && ib_stat.done) begin
                    div_start    = 1'b1;
                    ptclamp_next = ptclamp_reg || clamp_a || clamp_b;
                    state_next   = ST_RATIO;
                end
            end
            ST_RATIO: begin
                div_num = residual;
                div_den = sigma_reg;
                if (div_stat.done) begin
                    div_start    = 1'b1;
                    ptclamp_next = ptclamp_reg || div_clamp;
                    state_next   = ST_QUOT;
                end
            end
            ST_QUOT: begin
                if (div_stat.done) begin
                    sq_start     = 1'b1;
                    ptclamp_next = ptclamp_reg || div_clamp;
                    state_next   = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (sq_stat.done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!last_reg) begin
                    sum_next   = acc_sum;
                    seen_next  = acc_flag;
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = acc_sum;
                    m_idx_next   = dest_reg;
                    m_sat_next   = acc_flag;
                    sum_next     = '0;
                    seen_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, running sum and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            seen_reg    <= 1'b0;
            ptclamp_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            seen_reg    <= seen_next;
            ptclamp_reg <= ptclamp_next;
            m_valid_reg <= m_valid_next;
        end
        m_sum_reg <= m_sum_next;
        m_idx_reg <= m_idx_next;
        m_sat_reg <= m_sat_next;
        if (accept) begin
            obs_reg   <= s_observed;
            sigma_reg <= s_sigma;
            dest_reg  <= s_dest_index;
            last_reg  <= s_last_point;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_chi2_sum     = m_sum_reg;
    assign m_result_index = m_idx_reg;
    assign m_saturated    = m_sat_reg;

    // The divider reports completion only while the sequencer waits on it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_RATIO || state_reg == ST_QUOT))
        else $error("divider finished outside a divide step");

    // The squarer reports completion only in its own step.
    a_sq_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_stat.done |-> state_reg == ST_SQUARE)
        else $error("squarer finished outside the square step");

    // No serial unit is still running when a new item may be taken.
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(ia_stat.busy || ib_stat.busy || div_stat.busy || sq_stat.busy))
        else $error("new item possible while a unit is busy");

    // Within a pair the running sum never decreases.
    a_sum_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && !last_reg) |=> sum_reg >= $past(sum_reg))
        else $error("running sum decreased within a pair");

endmodule

`default_nettype wire

// ----- rtl/csa_interp.sv -----
// Bit-serial linear interpolation of one image's magnification.
`default_nettype none

module csa_interp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [csa_pkg::VAL_W-1:0]  sample,
    input  wire logic [csa_pkg::VAL_W-1:0]  slope,
    input  wire logic [csa_pkg::FR_W-1:0]   frac,
    input  wire logic                       outside,
    output logic [csa_pkg::VAL_W-1:0]       mag,
    output logic                            clamp,
    output csa_pkg::csa_stat_t              stat
);
    import csa_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [VAL_W+1:0] hi_reg;
    logic [FR_W-1:0]         fr_reg;
    logic [VAL_W-1:0]        slope_reg;
    logic [VAL_W-1:0]        sample_reg;
    logic                    outside_reg;
    logic [VAL_W-1:0]        mag_reg;
    logic                    clamp_reg;

    logic signed [VAL_W+1:0] addend;
    logic signed [VAL_W+1:0] hi_sum;
    logic signed [VAL_W+2:0] m_full;

    // One fraction bit per cycle: add the slope, then shift the partial product right.
    // After all fraction bits the upper part holds floor(frac * slope / 2^16).
    always_comb begin
        addend = fr_reg[0] ? $signed({{2{slope_reg[VAL_W-1]}}, slope_reg}) : '0;
        hi_sum = hi_reg + addend;
        m_full = $signed({3'b000, sample_reg}) + $signed({hi_reg[VAL_W+1], hi_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FR_W);
            end else if (busy_reg && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end else if (busy_reg) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Data path registers; the final cycle adds the sample and clamps.
    always_ff @(posedge aclk) begin
        if (start) begin
            hi_reg      <= '0;
            fr_reg      <= frac;
            slope_reg   <= slope;
            sample_reg  <= sample;
            outside_reg <= outside;
        end else if (busy_reg && cnt_reg != '0) begin
            hi_reg <= hi_sum >>> 1;
            fr_reg <= fr_reg >> 1;
        end else if (busy_reg) begin
            if (outside_reg) begin
                mag_reg   <= ONE_VAL;
                clamp_reg <= 1'b0;
            end else if (m_full < 0) begin
                mag_reg   <= '0;
                clamp_reg <= 1'b1;
            end else if (m_full > $signed({3'b000, VAL_MAX})) begin
                mag_reg   <= VAL_MAX;
                clamp_reg <= 1'b1;
            end else begin
                mag_reg   <= m_full[VAL_W-1:0];
                clamp_reg <= 1'b0;
            end
        end
    end

    assign mag       = mag_reg;
    assign clamp     = clamp_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/csa_div.sv -----
// Bit-serial restoring divider giving a saturated fixed-point quotient.
`default_nettype none

module csa_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [csa_pkg::VAL_W-1:0]  num,
    input  wire logic [csa_pkg::VAL_W-1:0]  den,
    output logic [csa_pkg::VAL_W-1:0]       quo,
    output logic                            clamp,
    output csa_pkg::csa_stat_t              stat
);
    import csa_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VAL_W-1:0]   rem_reg;
    logic [VAL_W-1:0]   bits_reg;
    logic [VAL_W-1:0]   den_reg;
    logic [VAL_W-1:0]   q_reg;
    logic [VAL_W-1:0]   quo_reg;
    logic               clamp_reg;

    logic [N_W-1:0]     n_full;
    logic [VAL_W-1:0]   rem_init;
    logic               sat;
    logic [VAL_W:0]     shifted;
    logic               ge;
    logic [VAL_W:0]     diff;
    logic [VAL_W-1:0]   rem_next;
    logic [VAL_W-1:0]   q_next;

    // The quotient overflows exactly when the bits above the low word already
    // reach the divisor; a zero divisor is caught by the same compare.
    always_comb begin
        n_full   = {num, FRAC_BITS'(0)};
        rem_init = VAL_W'(n_full >> VAL_W);
        sat      = rem_init >= den;
        shifted  = {rem_reg, bits_reg[VAL_W-1]};
        ge       = shifted >= {1'b0, den_reg};
        diff     = shifted - {1'b0, den_reg};
        rem_next = ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
        q_next   = {q_reg[VAL_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !sat;
                done_reg <= sat;
                cnt_reg  <= CNT_W'(VAL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= rem_init;
            bits_reg <= n_full[VAL_W-1:0];
            den_reg  <= den;
            q_reg    <= '0;
            if (sat) begin
                quo_reg   <= VAL_MAX;
                clamp_reg <= 1'b1;
            end
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            bits_reg <= bits_reg << 1;
            q_reg    <= q_next;
            if (cnt_reg == CNT_W'(1)) begin
                quo_reg   <= q_next;
                clamp_reg <= 1'b0;
            end
        end
    end

    assign quo       = quo_reg;
    assign clamp     = clamp_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/csa_square.sv -----
// Bit-serial squarer producing the scaled square of the residual quotient.
`default_nettype none

module csa_square (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [csa_pkg::VAL_W-1:0]  q,
    output logic [csa_pkg::SUM_W-1:0]       sq,
    output csa_pkg::csa_stat_t              stat
);
    import csa_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [VAL_W-1:0]     q_reg;
    logic [VAL_W-1:0]     hi_reg;
    logic [VAL_W-1:0]     lo_reg;
    logic [SUM_W-1:0]     sq_reg;

    logic [VAL_W:0]       hi_sum;
    logic [2*VAL_W-1:0]   prod_next;

    // Shift-add: the multiplier bits leave the low word as product bits enter it.
    always_comb begin
        hi_sum    = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, q_reg} : '0);
        prod_next = {hi_sum, lo_reg[VAL_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VAL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg  <= q;
            hi_reg <= '0;
            lo_reg <= q;
        end else if (busy_reg) begin
            hi_reg <= prod_next[2*VAL_W-1:VAL_W];
            lo_reg <= prod_next[VAL_W-1:0];
            if (cnt_reg == CNT_W'(1)) begin
                sq_reg <= SUM_W'(prod_next >> FRAC_BITS);
            end
        end
    end

    assign sq        = sq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
